/* rtl/core/ipd_pkg.sv */
`timescale 1ns / 1ps

package ipd_pkg;

	// Operation codes carried in the op field of an input item.
	typedef enum logic [1:0] {
		OP_REQUEST   = 2'd0,
		OP_WR_PEND   = 2'd1,
		OP_WR_ENABLE = 2'd2,
		OP_SERVICE   = 2'd3
	} op_t;

	// Dispatch sequencer: a taken service sends two stack writes.
	typedef enum logic [1:0] {
		PH_FIRST  = 2'b01,
		PH_SECOND = 2'b10
	} phase_t;

	localparam int unsigned NUM_SRC   = 5;
	localparam int unsigned SRC_IDX_W = 3;
	localparam logic [15:0] VEC_BASE  = 16'h0040;

	// One accepted input item.
	typedef struct packed {
		op_t         op;
		logic [4:0]  source_bits;
		logic [7:0]  write_value;
		logic [15:0] current_pc;
		logic [15:0] current_sp;
	} item_t;

	// One result item.
	typedef struct packed {
		logic        taken;
		logic        mem_write;
		logic [15:0] mem_address;
		logic [7:0]  mem_data;
		logic [15:0] new_pc;
		logic [15:0] new_sp;
		logic        clear_halt;
		logic        master_disable;
		logic [7:0]  pending_now;
		logic [7:0]  enable_now;
		logic        last;
	} result_t;

	// Outcome of the priority search over the ready sources.
	typedef struct packed {
		logic                 hit;
		logic [SRC_IDX_W-1:0] idx;
	} pick_t;

	// Lowest-numbered ready source wins.
	function automatic pick_t pick_lowest(input logic [NUM_SRC-1:0] ready);
		pick_t p;
		p.hit = 1'b0;
		p.idx = '0;
		for (int i = NUM_SRC - 1; i >= 0; i--) begin
			if (ready[i]) begin
				p.hit = 1'b1;
				p.idx = SRC_IDX_W'(i);
			end
		end
		return p;
	endfunction

	// Vector address of a source: base plus eight bytes per source.
	function automatic logic [15:0] vector_of(input logic [SRC_IDX_W-1:0] idx);
		return VEC_BASE + {10'd0, idx, 3'd0};
	endfunction

endpackage

/* rtl/core/ipd_in_reg.sv */
`timescale 1ns / 1ps

module ipd_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  ipd_pkg::item_t item,
	input  logic          retire,
	output logic          in_stall,
	output logic          valid_s1,
	output ipd_pkg::item_t item_s1
);
	import ipd_pkg::*;

	logic accept;

	// The register frees up in the same cycle its item retires.
	assign in_stall = valid_s1 & ~retire;
	assign accept   = in_valid & ~in_stall;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload is captured on each input transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

/* rtl/core/ipd_engine.sv */
`timescale 1ns / 1ps

module ipd_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  ipd_pkg::item_t  item_s1,
	input  logic            out_free,
	output logic            beat,
	output logic            retire,
	output ipd_pkg::result_t res
);
	import ipd_pkg::*;

	logic [7:0]           pend_q;
	logic [7:0]           en_q;
	logic [7:0]           pend_next;
	logic [7:0]           en_next;
	phase_t               phase_q;
	logic [SRC_IDX_W-1:0] idx_q;
	pick_t                pick;
	logic [15:0]          sp_m1;
	logic [15:0]          sp_m2;
	logic                 start_second;

	assign beat   = valid_s1 & out_free;
	assign retire = beat & res.last;

	assign pick  = pick_lowest(pend_q[NUM_SRC-1:0] & en_q[NUM_SRC-1:0]);
	assign sp_m1 = item_s1.current_sp - 16'd1;
	assign sp_m2 = item_s1.current_sp - 16'd2;

	// Next register values and the result of the current beat.
	always_comb begin
		pend_next    = pend_q;
		en_next      = en_q;
		start_second = 1'b0;
		res          = '0;
		res.last     = 1'b1;
		if (phase_q == PH_SECOND) begin
			res.taken          = 1'b1;
			res.mem_write      = 1'b1;
			res.mem_address    = sp_m2;
			res.mem_data       = item_s1.current_pc[7:0];
			res.new_pc         = vector_of(idx_q);
			res.new_sp         = sp_m2;
			res.clear_halt     = 1'b1;
			res.master_disable = 1'b1;
		end else begin
			case (item_s1.op)
				OP_REQUEST: begin
					pend_next = pend_q | {3'd0, item_s1.source_bits};
				end
				OP_WR_PEND: begin
					pend_next = item_s1.write_value;
				end
				OP_WR_ENABLE: begin
					en_next = item_s1.write_value;
				end
				OP_SERVICE: begin
					if (pick.hit) begin
						pend_next       = pend_q & ~(8'd1 << pick.idx);
						start_second    = 1'b1;
						res.taken       = 1'b1;
						res.mem_write   = 1'b1;
						res.mem_address = sp_m1;
						res.mem_data    = item_s1.current_pc[15:8];
						res.last        = 1'b0;
					end
				end
				default: begin
					pend_next = pend_q;
				end
			endcase
		end
		res.pending_now = pend_next;
		res.enable_now  = en_next;
	end

	// Pending, enable and sequencer state advance on each beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			en_q    <= '0;
			phase_q <= PH_FIRST;
		end else if (beat) begin
			pend_q  <= pend_next;
			en_q    <= en_next;
			phase_q <= start_second ? PH_SECOND : PH_FIRST;
		end
	end

	// Source index kept for the vector of the second write.
	always_ff @(posedge clk) begin
		if (beat && start_second) begin
			idx_q <= pick.idx;
		end
	end

endmodule

/* rtl/core/ipd_out_reg.sv */
`timescale 1ns / 1ps

module ipd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ipd_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_free,
	output logic             out_valid,
	output ipd_pkg::result_t res_q
);
	import ipd_pkg::*;

	// A new result may enter when the register is empty or being emptied.
	assign out_free = ~out_valid | ~out_stall;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

endmodule

/* rtl/core/priority_interrupt_dispatch.sv */
// Path: an item is held in the input register, and its results are loaded into the result register.
// Throughput: one item per cycle, while out_stall is low, for request, pending and
// enable writes and for a service with nothing ready; a taken service holds the
// engine until both of its stack writes have gone through the single result register.
// Reset: arst_n clears pending and enable to zero and empties both registers.
`timescale 1ns / 1ps

module priority_interrupt_dispatch (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [4:0]  source_bits,
	input  logic [7:0]  write_value,
	input  logic [15:0] current_pc,
	input  logic [15:0] current_sp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        taken,
	output logic        mem_write,
	output logic [15:0] mem_address,
	output logic [7:0]  mem_data,
	output logic [15:0] new_pc,
	output logic [15:0] new_sp,
	output logic        clear_halt,
	output logic        master_disable,
	output logic [7:0]  pending_now,
	output logic [7:0]  enable_now,
	output logic        last
);
	import ipd_pkg::*;

	item_t   item;
	item_t   item_s1;
	logic    valid_s1;
	logic    retire;
	logic    beat;
	logic    out_free;
	result_t res;
	result_t res_q;

	// Gather the input fields into one item.
	always_comb begin
		item.op          = op_t'(op);
		item.source_bits = source_bits;
		item.write_value = write_value;
		item.current_pc  = current_pc;
		item.current_sp  = current_sp;
	end

	ipd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item),
		.retire   (retire),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ipd_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.beat     (beat),
		.retire   (retire),
		.res      (res)
	);

	ipd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (beat),
		.res       (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// Spread the result register over the output ports.
	assign taken          = res_q.taken;
	assign mem_write      = res_q.mem_write;
	assign mem_address    = res_q.mem_address;
	assign mem_data       = res_q.mem_data;
	assign new_pc         = res_q.new_pc;
	assign new_sp         = res_q.new_sp;
	assign clear_halt     = res_q.clear_halt;
	assign master_disable = res_q.master_disable;
	assign pending_now    = res_q.pending_now;
	assign enable_now     = res_q.enable_now;
	assign last           = res_q.last;

endmodule

/* rtl/core/ipd_checker.sv */
`timescale 1ns / 1ps

module ipd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        taken,
	input logic        mem_write,
	input logic [15:0] mem_address,
	input logic [15:0] new_pc,
	input logic [15:0] new_sp,
	input logic        clear_halt,
	input logic        master_disable,
	input logic        last
);

	// A result that is not the last one is always the first stack write.
	a_first_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> taken && mem_write && !clear_halt && new_pc == 16'd0)
		else $error("first result of a service is not a stack write");

	// The second stack write follows at once, one address lower.
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
		out_valid && last && taken && mem_address == $past(mem_address) - 16'd1)
		else $error("second stack write missing or misplaced");

	// The final write of a dispatch carries the new stack pointer and flags.
	a_dispatch_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && taken |->
		clear_halt && master_disable && mem_write && new_sp == mem_address)
		else $error("dispatch tail fields inconsistent");

	// A result with nothing dispatched writes nothing.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !taken |-> !mem_write && last && !master_disable && new_sp == 16'd0)
		else $error("untaken result carries dispatch fields");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mem_address) && $stable(last))
		else $error("stalled result changed");

endmodule

bind priority_interrupt_dispatch ipd_checker u_ipd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.taken          (taken),
	.mem_write      (mem_write),
	.mem_address    (mem_address),
	.new_pc         (new_pc),
	.new_sp         (new_sp),
	.clear_halt     (clear_halt),
	.master_disable (master_disable),
	.last           (last)
);

/* tb/priority_interrupt_dispatch_checker.sv */
`timescale 1ns / 1ps

module priority_interrupt_dispatch_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [4:0]  source_bits,
	input  logic [7:0]  write_value,
	input  logic [15:0] current_pc,
	input  logic [15:0] current_sp,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        taken,
	input  logic        mem_write,
	input  logic [15:0] mem_address,
	input  logic [7:0]  mem_data,
	input  logic [15:0] new_pc,
	input  logic [15:0] new_sp,
	input  logic        clear_halt,
	input  logic        master_disable,
	input  logic [7:0]  pending_now,
	input  logic [7:0]  enable_now,
	input  logic        last,
	output int          fail_count,
	output int          results_due
);

	import ipd_pkg::*;

	// Shadow copies of the pending and enable registers.
	logic [7:0] pending_shadow;
	logic [7:0] enable_shadow;
	result_t    dispatch_q[$];
	int         errors = 0;

	assign fail_count = errors;

	// Applies one input transfer to the shadow registers and queues its results.
	function automatic void predict_dispatch(input op_t code, input logic [4:0] src,
		input logic [7:0] wv, input logic [15:0] pc, input logic [15:0] sp);
		result_t    res;
		logic [4:0] ready;
		int         winner;
		res = '0;
		winner = -1;
		case (code)
			OP_REQUEST:   pending_shadow = pending_shadow | {3'b000, src};
			OP_WR_PEND:   pending_shadow = wv;
			OP_WR_ENABLE: enable_shadow = wv;
			default: begin
				// Only the five low bits can dispatch; the lowest ready source wins.
				ready = pending_shadow[4:0] & enable_shadow[4:0];
				for (int i = NUM_SRC - 1; i >= 0; i--) begin
					if (ready[i])
						winner = i;
				end
			end
		endcase
		if (winner >= 0) begin
			pending_shadow[winner] = 1'b0;
			// High byte of the PC goes to SP-1 first.
			res.taken       = 1'b1;
			res.mem_write   = 1'b1;
			res.mem_address = sp - 16'd1;
			res.mem_data    = pc[15:8];
			res.pending_now = pending_shadow;
			res.enable_now  = enable_shadow;
			res.last        = 1'b0;
			dispatch_q.push_back(res);
			// Low byte at SP-2 carries the vector and the new stack pointer.
			res.mem_address    = sp - 16'd2;
			res.mem_data       = pc[7:0];
			res.new_pc         = VEC_BASE + 16'(winner * 8);
			res.new_sp         = sp - 16'd2;
			res.clear_halt     = 1'b1;
			res.master_disable = 1'b1;
			res.last           = 1'b1;
			dispatch_q.push_back(res);
		end else begin
			res.pending_now = pending_shadow;
			res.enable_now  = enable_shadow;
			res.last        = 1'b1;
			dispatch_q.push_back(res);
		end
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Results are compared before the same edge's input transfer is predicted,
	// so a result can never be matched against its own item too early.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pending_shadow = '0;
			enable_shadow = '0;
			dispatch_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (dispatch_q.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none, actual mem_address 0x%0h",
						$time, mem_address);
					errors++;
				end else begin
					want = dispatch_q.pop_front();
					check_field("taken", 16'(want.taken), 16'(taken));
					check_field("mem_write", 16'(want.mem_write), 16'(mem_write));
					check_field("mem_address", want.mem_address, mem_address);
					check_field("mem_data", 16'(want.mem_data), 16'(mem_data));
					check_field("new_pc", want.new_pc, new_pc);
					check_field("new_sp", want.new_sp, new_sp);
					check_field("clear_halt", 16'(want.clear_halt), 16'(clear_halt));
					check_field("master_disable", 16'(want.master_disable),
						16'(master_disable));
					check_field("pending_now", 16'(want.pending_now), 16'(pending_now));
					check_field("enable_now", 16'(want.enable_now), 16'(enable_now));
					check_field("last", 16'(want.last), 16'(last));
				end
			end
			if (in_valid && !in_stall)
				predict_dispatch(op_t'(op), source_bits, write_value, current_pc, current_sp);
		end
		results_due = dispatch_q.size();
	end

endmodule

/* tb/tb_priority_interrupt_dispatch.sv */
`timescale 1ns / 1ps

module tb_priority_interrupt_dispatch;

	import ipd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD      = 80;
	localparam int RANDOM_ITEMS   = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [4:0]  source_bits;
	logic [7:0]  write_value;
	logic [15:0] current_pc;
	logic [15:0] current_sp;
	logic        out_valid;
	logic        out_stall;
	logic        taken;
	logic        mem_write;
	logic [15:0] mem_address;
	logic [7:0]  mem_data;
	logic [15:0] new_pc;
	logic [15:0] new_sp;
	logic        clear_halt;
	logic        master_disable;
	logic [7:0]  pending_now;
	logic [7:0]  enable_now;
	logic        last;

	int fail_count;
	int results_due;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	priority_interrupt_dispatch u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .source_bits(source_bits), .write_value(write_value),
		.current_pc(current_pc), .current_sp(current_sp),
		.out_valid(out_valid), .out_stall(out_stall),
		.taken(taken), .mem_write(mem_write), .mem_address(mem_address),
		.mem_data(mem_data), .new_pc(new_pc), .new_sp(new_sp),
		.clear_halt(clear_halt), .master_disable(master_disable),
		.pending_now(pending_now), .enable_now(enable_now), .last(last)
	);

	priority_interrupt_dispatch_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .source_bits(source_bits), .write_value(write_value),
		.current_pc(current_pc), .current_sp(current_sp),
		.out_valid(out_valid), .out_stall(out_stall),
		.taken(taken), .mem_write(mem_write), .mem_address(mem_address),
		.mem_data(mem_data), .new_pc(new_pc), .new_sp(new_sp),
		.clear_halt(clear_halt), .master_disable(master_disable),
		.pending_now(pending_now), .enable_now(enable_now), .last(last),
		.fail_count(fail_count), .results_due(results_due)
	);

	// 20 ns clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle length: mostly none, sometimes short, rarely long.
	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!idle_on || roll < 65)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Offers one item and returns at the edge where it is transferred.
	task automatic send_item(input op_t code, input logic [4:0] src, input logic [7:0] wv,
		input logic [15:0] pc, input logic [15:0] sp);
		int unsigned gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= code;
		source_bits <= src;
		write_value <= wv;
		current_pc  <= pc;
		current_sp  <= sp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin
		int unsigned gap;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				gap = idle_gap();
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Ends the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		op_t         code;
		logic [7:0]  wv;
		logic [15:0] sp;
		int unsigned roll;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_REQUEST;
		source_bits = '0;
		write_value = '0;
		current_pc  = '0;
		current_sp  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: nothing pending, full priority walk, stack wrap and upper bits.
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'h1234, 16'hfffe);
		send_item(OP_WR_ENABLE, 5'h00, 8'hff, 16'h0000, 16'h0000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'hffff, 16'h0100);
		send_item(OP_REQUEST, 5'h1f, 8'h00, 16'h0000, 16'h0000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'hffff, 16'h0000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'h0000, 16'h0001);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'hff00, 16'hffff);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'h00ff, 16'h0002);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'ha55a, 16'hc000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'h5aa5, 16'h8000);
		send_item(OP_WR_PEND, 5'h00, 8'he0, 16'h0000, 16'h0000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'h4321, 16'hdff0);
		send_item(OP_REQUEST, 5'h00, 8'hff, 16'hffff, 16'hffff);
		send_item(OP_WR_ENABLE, 5'h1f, 8'h00, 16'h0000, 16'h0000);
		send_item(OP_WR_PEND, 5'h00, 8'hff, 16'h0000, 16'h0000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'h0100, 16'h0200);
		send_item(OP_WR_ENABLE, 5'h00, 8'h10, 16'h0000, 16'h0000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'hbeef, 16'h0001);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'hbeef, 16'h0001);
		send_item(OP_WR_ENABLE, 5'h00, 8'h0a, 16'h0000, 16'h0000);
		send_item(OP_SERVICE, 5'h00, 8'h00, 16'h8001, 16'h7fff);
		send_item(OP_REQUEST, 5'h10, 8'h00, 16'h0000, 16'h0000);
		send_item(OP_WR_PEND, 5'h00, 8'h00, 16'h0000, 16'h0000);

		// Random: mostly requests and services so that dispatches keep happening.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Back-to-back items against a long receiver hold-off fill the block.
			if (n == 100) begin
				idle_on = 1'b0;
				hold_req = 1'b1;
			end
			if (n == 140)
				idle_on = 1'b1;
			// A stretch with no idling on either side.
			if (n == 260)
				idle_on = 1'b0;
			if (n == 320)
				idle_on = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 30)
				code = OP_REQUEST;
			else if (roll < 42)
				code = OP_WR_PEND;
			else if (roll < 52)
				code = OP_WR_ENABLE;
			else
				code = OP_SERVICE;
			wv = 8'($urandom_range(0, 255));
			if (code == OP_WR_ENABLE && $urandom_range(0, 4) == 0)
				wv = 8'hff;
			roll = $urandom_range(0, 19);
			if (roll == 0)
				sp = 16'h0000;
			else if (roll == 1)
				sp = 16'h0001;
			else if (roll == 2)
				sp = 16'hffff;
			else
				sp = 16'($urandom_range(0, 65535));
			send_item(code, 5'($urandom_range(0, 31)), wv, 16'($urandom_range(0, 65535)), sp);
		end
		in_valid <= 1'b0;

		// Let the checker count the final transfer, then drain and wait for strays.
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
